/* design/sxg_pkg.sv */
// shared types and constants for the step count to sexagesimal converter
// no dependencies; imported by step_count_to_sexagesimal and the testbench
`default_nettype none

package sxg_pkg;

    // register indexes on the configuration port
    typedef enum logic [1:0] {
        REG_RA_SPS  = 2'd0,
        REG_DEC_SPD = 2'd1,
        REG_DEC_SPM = 2'd2,
        REG_DEC_SPS = 2'd3
    } sxg_reg_e;

    // axis codes
    localparam logic ACT_RA  = 1'b0;
    localparam logic ACT_DEC = 1'b1;

    // register reset values
    localparam logic [15:0] RA_SPS_RESET  = 16'd100;
    localparam logic [23:0] DEC_SPD_RESET = 24'd360000;
    localparam logic [19:0] DEC_SPM_RESET = 20'd6000;
    localparam logic [15:0] DEC_SPS_RESET = 16'd100;

    // time and angle constants
    localparam logic [11:0] SEC_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SEC_PER_MIN  = 6'd60;
    localparam logic [6:0]  RA_HOURS     = 7'd24;
    localparam logic [6:0]  DEC_MAX      = 7'd90;
    localparam logic [5:0]  UNIT_MAX     = 6'd59;
    localparam logic [3:0]  TENTHS_MAX   = 4'd9;

    // sideband carried through the major unit division
    typedef struct packed {
        logic action;
        logic precise;
        logic neg;
    } sxg_side1_t;

    // sideband carried through the minute division
    typedef struct packed {
        logic       action;
        logic       precise;
        logic       neg;
        logic [6:0] q_major;
        logic       ra_neg;
        logic       ra_high;
        logic       dec_high;
    } sxg_side2_t;

    // sideband carried through the second division
    typedef struct packed {
        sxg_side2_t s2;
        logic [9:0] q_min;
        logic       ovf_min;
    } sxg_side3_t;

endpackage

`default_nettype wire

/* design/sxg_div.sv */
// pipelined restoring divider, one quotient bit per stage plus an overflow stage
// depends on no package; used three times by step_count_to_sexagesimal
`default_nettype none

module sxg_div #(
    parameter int W  = 37,
    parameter int QB = 7,
    parameter int SW = 1
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic          in_valid,
    input  wire logic [W-1:0]  num,
    input  wire logic [W-1:0]  den,
    input  wire logic [SW-1:0] side_in,
    output logic               out_valid,
    output logic [QB-1:0]      quot,
    output logic               ovf,
    output logic [W-1:0]       rem,
    output logic [W-1:0]       den_out,
    output logic [SW-1:0]      side_out
);

    logic          valid_reg [QB+1];
    logic [W-1:0]  rem_reg   [QB+1];
    logic [W-1:0]  den_reg   [QB+1];
    logic [QB-1:0] quot_reg  [QB+1];
    logic          ovf_reg   [QB+1];
    logic [SW-1:0] side_reg  [QB+1];

    logic [W-1:0]  rem_next  [QB+1];
    logic [QB-1:0] quot_next [QB+1];
    logic          ovf_next;

    // first stage: quotient too large for QB bits
    // a divisor whose shifted copy leaves W bits is always above the numerator
    assign ovf_next     = ((den >> (W - QB)) == '0) ? (num >= (den << QB)) : 1'b0;
    assign rem_next[0]  = num;
    assign quot_next[0] = '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rem_reg[0]  <= rem_next[0];
            den_reg[0]  <= den;
            quot_reg[0] <= quot_next[0];
            ovf_reg[0]  <= ovf_next;
            side_reg[0] <= side_in;
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar j = 1; j <= QB; j++)
    begin : g_step
        localparam int K = QB - j;
        logic [W-1:0] trial;
        logic         fits;
        logic         take;

        assign trial = den_reg[j-1] << K;
        assign fits  = (den_reg[j-1] >> (W - K)) == '0;
        assign take  = !ovf_reg[j-1] && fits && (rem_reg[j-1] >= trial);

        always_comb
        begin
            rem_next[j]  = take ? (rem_reg[j-1] - trial) : rem_reg[j-1];
            quot_next[j] = quot_reg[j-1];
            quot_next[j][K] = take;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (advance)
            begin
                valid_reg[j] <= valid_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[j]  <= rem_next[j];
                den_reg[j]  <= den_reg[j-1];
                quot_reg[j] <= quot_next[j];
                ovf_reg[j]  <= ovf_reg[j-1];
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    assign out_valid = valid_reg[QB];
    assign quot      = quot_reg[QB];
    assign ovf       = ovf_reg[QB];
    assign rem       = rem_reg[QB];
    assign den_out   = den_reg[QB];
    assign side_out  = side_reg[QB];

endmodule

`default_nettype wire

/* design/step_count_to_sexagesimal.sv */
// top level: configuration registers, three divider pipelines and result logic
// depends on sxg_pkg and sxg_div
// pipeline: 8 + 29 + 7 divider stages and one output register between request and result
// throughput: one request per cycle, set by the one-bit-per-stage divider pipelines
// a stall at the output holds every stage; in_ready follows out_ready combinationally
// reset: rst_n clears all valid bits and loads the default steps registers
`default_nettype none

module step_count_to_sexagesimal #(
    parameter int POSITION_WIDTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             action,
    input  wire logic signed [POSITION_WIDTH-1:0] position,
    input  wire logic                             precise,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  negative,
    output logic [6:0]                            major,
    output logic [5:0]                            minutes,
    output logic [5:0]                            seconds,
    output logic [3:0]                            tenths,
    output logic                                  range_error,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [3:0]                       paddr,
    input  wire logic [31:0]                      pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    import sxg_pkg::*;

    localparam int W   = (POSITION_WIDTH > 36) ? POSITION_WIDTH + 1 : 37;
    localparam int S1W = $bits(sxg_side1_t);
    localparam int S2W = $bits(sxg_side2_t);
    localparam int S3W = $bits(sxg_side3_t);

    // configuration registers
    logic [15:0] ra_sps_reg;
    logic [23:0] dec_spd_reg;
    logic [19:0] dec_spm_reg;
    logic [15:0] dec_sps_reg;
    logic        wr_en;
    sxg_reg_e    wr_idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = sxg_reg_e'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ra_sps_reg  <= RA_SPS_RESET;
            dec_spd_reg <= DEC_SPD_RESET;
            dec_spm_reg <= DEC_SPM_RESET;
            dec_sps_reg <= DEC_SPS_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                REG_RA_SPS:  ra_sps_reg  <= pwdata[15:0];
                REG_DEC_SPD: dec_spd_reg <= pwdata[23:0];
                REG_DEC_SPM: dec_spm_reg <= pwdata[19:0];
                REG_DEC_SPS: dec_sps_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        unique case (wr_idx)
            REG_RA_SPS:  prdata = {16'd0, ra_sps_reg};
            REG_DEC_SPD: prdata = {8'd0, dec_spd_reg};
            REG_DEC_SPM: prdata = {12'd0, dec_spm_reg};
            REG_DEC_SPS: prdata = {16'd0, dec_sps_reg};
            default:     prdata = '0;
        endcase
    end

    // zero steps registers count as one
    logic [15:0] ra_sps;
    logic [23:0] dec_spd;
    logic [19:0] dec_spm;
    logic [15:0] dec_sps;
    logic [27:0] ra_per_hour;
    logic [21:0] ra_per_min;

    assign ra_sps      = (ra_sps_reg == '0) ? 16'd1 : ra_sps_reg;
    assign dec_spd     = (dec_spd_reg == '0) ? 24'd1 : dec_spd_reg;
    assign dec_spm     = (dec_spm_reg == '0) ? 20'd1 : dec_spm_reg;
    assign dec_sps     = (dec_sps_reg == '0) ? 16'd1 : dec_sps_reg;
    assign ra_per_hour = 28'(ra_sps) * 28'(SEC_PER_HOUR);
    assign ra_per_min  = 22'(ra_sps) * 22'(SEC_PER_MIN);

    // global advance: every stage moves unless the output is stalled
    logic out_valid_reg;
    logic advance;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = advance;

    // magnitude and sign of the request position
    logic                      pos_neg;
    logic [POSITION_WIDTH-1:0] pos_mag;
    logic [W-1:0]              num1;
    logic [W-1:0]              den1;
    sxg_side1_t                side1_in;

    assign pos_neg  = position[POSITION_WIDTH-1];
    assign pos_mag  = pos_neg ? (~position + 1'b1) : position;
    assign num1     = W'(pos_mag);
    assign den1     = (action == ACT_DEC) ? W'(dec_spd) : W'(ra_per_hour);
    assign side1_in = '{action: action, precise: precise, neg: pos_neg};

    // major unit division
    logic          v1;
    logic [6:0]    q1;
    logic          ovf1;
    logic [W-1:0]  rem1;
    logic [W-1:0]  den1_out;
    logic [S1W-1:0] side1_vec;

    sxg_div #(.W(W), .QB(7), .SW(S1W)) u_div_major (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (in_valid),
        .num      (num1),
        .den      (den1),
        .side_in  (side1_in),
        .out_valid(v1),
        .quot     (q1),
        .ovf      (ovf1),
        .rem      (rem1),
        .den_out  (den1_out),
        .side_out (side1_vec)
    );

    // range checks and numerator for the minute division
    sxg_side1_t   side1;
    sxg_side2_t   side2_in;
    logic [W-1:0] num2;
    logic [W-1:0] den2;

    assign side1 = side1_vec;
    assign num2  = side1.precise ? rem1 : ((rem1 << 3) + (rem1 << 1));
    assign den2  = (side1.action == ACT_DEC) ? W'(dec_spm) : W'(ra_per_min);

    always_comb
    begin
        side2_in.action   = side1.action;
        side2_in.precise  = side1.precise;
        side2_in.neg      = side1.neg;
        side2_in.q_major  = q1;
        side2_in.ra_neg   = side1.neg;
        side2_in.ra_high  = ovf1 || (q1 >= RA_HOURS);
        side2_in.dec_high = ovf1 || (q1 > DEC_MAX) || ((q1 == DEC_MAX) && (rem1 != '0));
    end

    // minute or tenth division, wide enough that the remainder is always exact
    logic           v2;
    logic [27:0]    q2;
    logic           ovf2;
    logic [W-1:0]   rem2;
    logic [W-1:0]   den2_out;
    logic [S2W-1:0] side2_vec;

    sxg_div #(.W(W), .QB(28), .SW(S2W)) u_div_minute (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (v1),
        .num      (num2),
        .den      (den2),
        .side_in  (side2_in),
        .out_valid(v2),
        .quot     (q2),
        .ovf      (ovf2),
        .rem      (rem2),
        .den_out  (den2_out),
        .side_out (side2_vec)
    );

    sxg_side2_t   side2;
    sxg_side3_t   side3_in;
    logic [W-1:0] den3;
    logic         min_big;

    assign side2    = side2_vec;
    assign den3     = (side2.action == ACT_DEC) ? W'(dec_sps) : W'(ra_sps);
    assign min_big  = ovf2 || (q2[27:10] != '0);
    assign side3_in = '{s2: side2, q_min: q2[9:0], ovf_min: min_big};

    // second division
    logic           v3;
    logic [5:0]     q3;
    logic           ovf3;
    logic [W-1:0]   rem3;
    logic [W-1:0]   den3_out;
    logic [S3W-1:0] side3_vec;

    sxg_div #(.W(W), .QB(6), .SW(S3W)) u_div_second (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (v2),
        .num      (rem2),
        .den      (den3),
        .side_in  (side3_in),
        .out_valid(v3),
        .quot     (q3),
        .ovf      (ovf3),
        .rem      (rem3),
        .den_out  (den3_out),
        .side_out (side3_vec)
    );

    // rounding, carry, clamping and error overrides
    sxg_side3_t  side3;
    logic        rnd;
    logic [5:0]  m_clamp;
    logic [6:0]  s_full;
    logic [6:0]  m_inc;
    logic [7:0]  maj_inc;
    logic [17:0] t_prod;
    logic [6:0]  t_min;
    logic [3:0]  t_ten;
    logic        neg_next;
    logic [6:0]  major_next;
    logic [5:0]  minutes_next;
    logic [5:0]  seconds_next;
    logic [3:0]  tenths_next;
    logic        err_next;

    assign side3   = side3_vec;
    assign rnd     = rem3 > (den3_out >> 1);
    assign m_clamp = (side3.ovf_min || (side3.q_min > 10'(UNIT_MAX))) ?
                     UNIT_MAX : side3.q_min[5:0];
    assign s_full  = ovf3 ? 7'h7F : ({1'b0, q3} + 7'(rnd));
    assign m_inc   = {1'b0, m_clamp} + 7'd1;
    assign maj_inc = {1'b0, side3.s2.q_major} + 8'd1;
    // divide by ten through a reciprocal, exact below 1029
    assign t_prod  = 18'(side3.q_min) * 18'd205;
    assign t_min   = t_prod[17:11];
    assign t_ten   = 4'(side3.q_min - (10'(t_min) * 10'd10));

    always_comb
    begin
        neg_next     = (side3.s2.action == ACT_DEC) ? side3.s2.neg : 1'b0;
        major_next   = side3.s2.q_major;
        minutes_next = m_clamp;
        seconds_next = '0;
        tenths_next  = '0;
        err_next     = 1'b0;

        if (side3.s2.precise)
        begin
            if (s_full == 7'(SEC_PER_MIN))
            begin
                seconds_next = '0;
                if (m_inc == 7'(SEC_PER_MIN))
                begin
                    minutes_next = '0;
                    if (side3.s2.action == ACT_RA)
                    begin
                        major_next = (maj_inc == 8'(RA_HOURS)) ? 7'd0 : maj_inc[6:0];
                    end
                    else
                    begin
                        major_next = (maj_inc > 8'(DEC_MAX)) ? DEC_MAX : maj_inc[6:0];
                    end
                end
                else
                begin
                    minutes_next = m_inc[5:0];
                end
            end
            else
            begin
                seconds_next = (s_full > 7'(UNIT_MAX)) ? UNIT_MAX : s_full[5:0];
            end
        end
        else
        begin
            if (side3.ovf_min || (t_min > 7'(UNIT_MAX)))
            begin
                minutes_next = UNIT_MAX;
                tenths_next  = TENTHS_MAX;
            end
            else
            begin
                minutes_next = t_min[5:0];
                tenths_next  = t_ten;
            end
        end

        // out of range cases replace every field but the sign
        if (side3.s2.action == ACT_RA)
        begin
            if (side3.s2.ra_neg)
            begin
                major_next   = '0;
                minutes_next = '0;
                seconds_next = '0;
                tenths_next  = '0;
                err_next     = 1'b1;
            end
            else if (side3.s2.ra_high)
            begin
                major_next   = RA_HOURS - 7'd1;
                minutes_next = UNIT_MAX;
                seconds_next = side3.s2.precise ? UNIT_MAX : 6'd0;
                tenths_next  = side3.s2.precise ? 4'd0 : TENTHS_MAX;
                err_next     = 1'b1;
            end
        end
        else if (side3.s2.dec_high)
        begin
            major_next   = DEC_MAX;
            minutes_next = '0;
            seconds_next = '0;
            tenths_next  = '0;
            err_next     = 1'b1;
        end
    end

    // output register
    logic [6:0] major_reg;
    logic [5:0] minutes_reg;
    logic [5:0] seconds_reg;
    logic [3:0] tenths_reg;
    logic       negative_reg;
    logic       range_error_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= v3;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            negative_reg    <= neg_next;
            major_reg       <= major_next;
            minutes_reg     <= minutes_next;
            seconds_reg     <= seconds_next;
            tenths_reg      <= tenths_next;
            range_error_reg <= err_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign negative    = negative_reg;
    assign major       = major_reg;
    assign minutes     = minutes_reg;
    assign seconds     = seconds_reg;
    assign tenths      = tenths_reg;
    assign range_error = range_error_reg;

    // a stalled result holds back new requests
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request taken while result stalled");

    // sexagesimal fields stay in range
    a_fields_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (minutes <= UNIT_MAX && seconds <= UNIT_MAX && tenths <= TENTHS_MAX
                       && major <= DEC_MAX))
        else $error("result field out of range");

    // seconds and tenths never both present
    a_mode_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (seconds == '0 || tenths == '0))
        else $error("seconds and tenths both set");

    // a minus sign with an error is a saturated declination
    a_dec_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error && negative) |-> (major == DEC_MAX && minutes == '0))
        else $error("saturated declination malformed");

endmodule

`default_nettype wire

/* dv/tb.sv */
// testbench for step_count_to_sexagesimal: random and directed positions on both axes
// depends on sxg_pkg and the design top; predicts each coordinate and checks it in order
`timescale 1ns / 1ps

typedef struct packed {
    logic       negative;
    logic [6:0] major;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [3:0] tenths;
    logic       range_error;
} coord_t;

class coord_board;
    coord_t pending[$];
    int     errors;
    int     checked;
    longint ra_sps;
    longint dec_spd;
    longint dec_spm;
    longint dec_sps;

    function new();
        errors = 0;
        checked = 0;
        ra_sps = 100;
        dec_spd = 360000;
        dec_spm = 6000;
        dec_sps = 100;
    endfunction

    function coord_t convert(logic act, logic signed [31:0] pos, logic prec);
        coord_t  c;
        longint  mag;
        longint  sps;
        longint  spd;
        longint  spm;
        longint  h;
        longint  rh;
        longint  m;
        longint  rm;
        longint  s;
        longint  t;
        longint  d;
        longint  rd;
        bit      neg;
        c = '0;
        neg = pos[31];
        mag = neg ? -longint'(pos) : longint'(pos);
        if (act == sxg_pkg::ACT_RA)
        begin
            sps = (ra_sps == 0) ? 1 : ra_sps;
            if (neg)
            begin
                c.range_error = 1;
                return c;
            end
            h = mag / (3600 * sps);
            rh = mag % (3600 * sps);
            if (h >= 24)
            begin
                c.major = 23;
                c.minutes = 59;
                c.range_error = 1;
                if (prec)
                    c.seconds = 59;
                else
                    c.tenths = 9;
                return c;
            end
            if (prec)
            begin
                m = rh / (60 * sps);
                rm = rh % (60 * sps);
                s = rm / sps;
                if (rm % sps > sps / 2)
                    s++;
                if (s == 60)
                begin
                    s = 0;
                    m++;
                    if (m == 60)
                    begin
                        m = 0;
                        h++;
                        if (h == 24)
                            h = 0;
                    end
                end
                c.major = h;
                c.minutes = m;
                c.seconds = s;
            end
            else
            begin
                t = (10 * rh) / (60 * sps);
                c.major = h;
                c.minutes = t / 10;
                c.tenths = t % 10;
            end
            return c;
        end
        spd = (dec_spd == 0) ? 1 : dec_spd;
        spm = (dec_spm == 0) ? 1 : dec_spm;
        sps = (dec_sps == 0) ? 1 : dec_sps;
        d = mag / spd;
        rd = mag % spd;
        c.negative = neg;
        if (d > 90 || (d == 90 && rd != 0))
        begin
            c.major = 90;
            c.range_error = 1;
            return c;
        end
        if (prec)
        begin
            m = rd / spm;
            rm = rd % spm;
            s = rm / sps;
            if (rm % sps > sps / 2)
                s++;
            if (m > 59)
                m = 59;
            if (s == 60)
            begin
                s = 0;
                m++;
                if (m == 60)
                begin
                    m = 0;
                    d++;
                    if (d > 90)
                        d = 90;
                end
            end
            else if (s > 59)
                s = 59;
            c.major = d;
            c.minutes = m;
            c.seconds = s;
        end
        else
        begin
            t = (10 * rd) / spm;
            m = t / 10;
            c.tenths = t % 10;
            if (m > 59)
            begin
                m = 59;
                c.tenths = 9;
            end
            c.major = d;
            c.minutes = m;
        end
        return c;
    endfunction

    function void note_request(logic act, logic signed [31:0] pos, logic prec);
        pending.push_back(convert(act, pos, prec));
    endfunction

    function void check_coord(coord_t got);
        coord_t want;
        if (pending.size() == 0)
        begin
            $error("unexpected result %p", got);
            errors++;
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got.negative !== want.negative)
        begin
            $error("negative: expected %0d actual %0d", want.negative, got.negative);
            errors++;
        end
        if (got.major !== want.major)
        begin
            $error("major: expected %0d actual %0d", want.major, got.major);
            errors++;
        end
        if (got.minutes !== want.minutes)
        begin
            $error("minutes: expected %0d actual %0d", want.minutes, got.minutes);
            errors++;
        end
        if (got.seconds !== want.seconds)
        begin
            $error("seconds: expected %0d actual %0d", want.seconds, got.seconds);
            errors++;
        end
        if (got.tenths !== want.tenths)
        begin
            $error("tenths: expected %0d actual %0d", want.tenths, got.tenths);
            errors++;
        end
        if (got.range_error !== want.range_error)
        begin
            $error("range_error: expected %0d actual %0d", want.range_error,
                   got.range_error);
            errors++;
        end
    endfunction
endclass

module tb;
    import sxg_pkg::*;

    localparam int IDLE_LIMIT = 20000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic               action;
    logic signed [31:0] position;
    logic               precise;
    logic               out_valid;
    logic               out_ready;
    logic               negative;
    logic [6:0]         major;
    logic [5:0]         minutes;
    logic [5:0]         seconds;
    logic [3:0]         tenths;
    logic               range_error;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [3:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    coord_board board;
    int         idle_cycles;
    int         sent;
    bit         long_hold;

    step_count_to_sexagesimal #(.POSITION_WIDTH(32)) uut (.*);

    // clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // register write over the configuration port
    task automatic write_reg(sxg_reg_e idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 4'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_RA_SPS:  board.ra_sps = val[15:0];
            REG_DEC_SPD: board.dec_spd = val[23:0];
            REG_DEC_SPM: board.dec_spm = val[19:0];
            default:     board.dec_sps = val[15:0];
        endcase
    endtask

    task automatic set_steps(int ra, int spd, int spm, int sps);
        write_reg(REG_RA_SPS, ra);
        write_reg(REG_DEC_SPD, spd);
        write_reg(REG_DEC_SPM, spm);
        write_reg(REG_DEC_SPS, sps);
    endtask

    // offer one request and hold it until accepted
    task automatic send_request(logic act, logic signed [31:0] pos, logic prec);
        in_valid <= 1'b1;
        action <= act;
        position <= pos;
        precise <= prec;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(act, pos, prec);
        sent++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        drop_valid();
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    // positions near interesting boundaries for the current steps
    function automatic logic signed [31:0] pick_position(logic act);
        longint unit;
        int     sel;
        sel = $urandom_range(0, 9);
        unit = (act == ACT_RA) ? board.ra_sps * 3600 : board.dec_spd;
        if (unit == 0)
            unit = 1;
        case (sel)
            0, 1: return $urandom;
            2: return -$urandom_range(0, 1000);
            3: return unit * $urandom_range(0, 95) + $urandom_range(0, 3) - 2;
            4: return unit * 24 - $urandom_range(0, 200);
            5: return unit * 90 - $urandom_range(0, 200) + 100;
            default: return $urandom % (unit * 26);
        endcase
    endfunction

    // receiver: stall pattern plus one long hold-off
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (120) @(posedge clk);
                long_hold = 0;
            end
            else
                out_ready <= ($urandom_range(0, 3) != 0) || (sent % 200 < 40);
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_coord('{negative, major, minutes, seconds, tenths, range_error});
    end

    // watchdog on accepted traffic
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d results pending", board.pending.size());
            $display("tb: errors");
            $finish;
        end
    end

    initial
    begin
        int phase;
        int burst;
        logic act;
        board = new();
        idle_cycles = 0;
        sent = 0;
        long_hold = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        action = 1'b0;
        position = '0;
        precise = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        clk = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset steps, field extremes, rounding and range cases
        send_request(ACT_RA, 32'sh7fffffff, 1'b1);
        send_request(ACT_RA, 32'sh80000000, 1'b1);
        send_request(ACT_RA, -1, 1'b0);
        send_request(ACT_RA, 0, 1'b1);
        send_request(ACT_RA, 0, 1'b0);
        send_request(ACT_RA, 8640000, 1'b1);
        send_request(ACT_RA, 8640000 - 1, 1'b0);
        send_request(ACT_RA, 8640000 - 40, 1'b1);
        send_request(ACT_RA, 8640000 - 50, 1'b1);
        send_request(ACT_RA, 359951, 1'b1);
        send_request(ACT_DEC, 32400000, 1'b1);
        send_request(ACT_DEC, 32400001, 1'b0);
        send_request(ACT_DEC, -32400001, 1'b1);
        send_request(ACT_DEC, 32399960, 1'b1);
        send_request(ACT_DEC, -359951, 1'b1);
        send_request(ACT_DEC, 32'sh80000000, 1'b0);
        send_request(ACT_DEC, 32'sh7fffffff, 1'b1);
        send_request(ACT_DEC, -5999, 1'b0);
        drain();

        // inconsistent and zero registers, then extremes
        set_steps(0, 0, 0, 0);
        send_request(ACT_RA, 86399, 1'b1);
        send_request(ACT_DEC, 45, 1'b0);
        drain();
        set_steps(3, 100000, 200, 7);
        send_request(ACT_DEC, 99999, 1'b1);
        send_request(ACT_DEC, 99999, 1'b0);
        send_request(ACT_DEC, 13900, 1'b1);
        drain();

        // minute count far beyond the hour with a small leftover
        set_steps(3, 16000000, 5000, 7);
        send_request(ACT_DEC, 15999999, 1'b1);
        send_request(ACT_DEC, 15000012, 1'b1);
        drain();

        // random phases through several register settings
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: set_steps(100, 360000, 6000, 100);
                1: set_steps(65535, 16777215, 1048575, 65535);
                2: set_steps(1, 1, 1, 1);
                3: set_steps($urandom_range(1, 65535), $urandom_range(1, 16777215),
                             $urandom_range(1, 1048575), $urandom_range(1, 65535));
                4: set_steps(7, 3600 * 7, 60 * 7, 7);
                default: set_steps($urandom_range(1, 300), $urandom_range(1, 400000),
                                   $urandom_range(1, 7000), $urandom_range(1, 200));
            endcase
            if (phase == 2)
                long_hold = 1;
            burst = 0;
            while (burst < 140)
            begin
                act = $urandom_range(0, 1);
                send_request(act, pick_position(act), $urandom_range(0, 1));
                burst++;
                if ($urandom_range(0, 5) == 0)
                begin
                    drop_valid();
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
            end
            drain();
        end

        $display("tb: %0d requests over directed corners and six random steps phases",
                 sent);
        $display("tb: %0d results checked", board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule

/* files.f */
design/sxg_pkg.sv
design/sxg_div.sv
design/step_count_to_sexagesimal.sv
dv/tb.sv
